// File: src/pwpsc_pkg.sv
// ----------------------------------------------------------------------------
// Pilot window peak classifier package
// Shared types, widths and codes for the control-pilot peak classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package pwpsc_pkg;

  // Field widths.
  localparam int unsigned CodeW      = 12;
  localparam int unsigned SlopeW     = 20;
  localparam int unsigned InterceptW = 31;
  localparam int unsigned ProdW      = CodeW + SlopeW;
  localparam int unsigned MvW        = 15;
  localparam int unsigned StateW     = 3;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 32;

  // Pilot voltage in signed millivolts.
  typedef logic signed [MvW-1:0] mv_t;

  localparam mv_t MV_MIN = -15'sd16384;
  localparam mv_t MV_MAX = 15'sd16383;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_SLOPE     = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTERCEPT = 2'd1;

  // Pilot states.
  typedef enum logic [StateW-1:0] {
    PILOT_A = 3'd0,
    PILOT_B = 3'd1,
    PILOT_C = 3'd2,
    PILOT_D = 3'd3,
    PILOT_E = 3'd4,
    PILOT_F = 3'd5
  } pilot_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_SHIFT = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DONE  = 2'd3
  } fsm_e;

  // Strict band classification; a peak in a gap keeps the previous state.
  function automatic pilot_e classify(input mv_t p, input pilot_e prev);
    pilot_e res;
    res = prev;
    if (p > 15'sd10000) begin
      res = PILOT_A;
    end else if (p < 15'sd10000 && p > 15'sd8000) begin
      res = PILOT_B;
    end else if (p < 15'sd7000 && p > 15'sd5000) begin
      res = PILOT_C;
    end else if (p < 15'sd4000 && p > 15'sd2000) begin
      res = PILOT_D;
    end else if (p < 15'sd1000 && p > -15'sd1000) begin
      res = PILOT_E;
    end else if (p < -15'sd11000 && p > -15'sd13000) begin
      res = PILOT_F;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// File: src/pwpsc_conv.sv
// ----------------------------------------------------------------------------
// Pilot code to millivolt converter
// Registers code * slope, then subtracts the offset, floors by 2^16 and
// saturates to the signed 15-bit millivolt range.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpsc_conv
  import pwpsc_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  load_i,
  input  wire logic [CodeW-1:0]      code_i,
  input  wire logic [SlopeW-1:0]     slope_i,
  input  wire logic [InterceptW-1:0] intercept_i,
  output mv_t                        mv_o
);

  logic [ProdW-1:0]          prod_q;
  logic [ProdW-1:0]          prod_d;
  logic signed [ProdW:0]     diff;
  logic signed [ProdW-16:0]  mv_wide;

  // Product register, loaded when a word is accepted.
  assign prod_d = ProdW'(code_i) * ProdW'(slope_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (load_i) begin
      prod_q <= prod_d;
    end
  end

  // Offset removal; the upper bits of the difference are the floored quotient.
  assign diff    = $signed({1'b0, prod_q}) - $signed({2'b00, intercept_i});
  assign mv_wide = diff[ProdW:16];

  // Saturate to the stored millivolt range.
  always_comb begin
    if (mv_wide < $signed((ProdW-15)'(MV_MIN))) begin
      mv_o = MV_MIN;
    end else if (mv_wide > $signed((ProdW-15)'(MV_MAX))) begin
      mv_o = MV_MAX;
    end else begin
      mv_o = mv_wide[MvW-1:0];
    end
  end

endmodule

`default_nettype wire

// File: src/pwpsc_cell.sv
// ----------------------------------------------------------------------------
// Window cell
// Holds one window entry, passes it to the next cell on a shift, and keeps
// a running maximum that moves one cell down the row each cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pwpsc_cell
  import pwpsc_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic shift_i,
  input  wire mv_t  val_i,
  input  wire mv_t  max_i,
  output mv_t       val_o,
  output mv_t       max_o
);

  mv_t val_q;
  mv_t max_q;
  mv_t max_d;

  // Running maximum of this cell and everything upstream.
  assign max_d = (val_q > max_i) ? val_q : max_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q <= '0;
      max_q <= '0;
    end else begin
      max_q <= max_d;
      if (shift_i) begin
        val_q <= val_i;
      end
    end
  end

  assign val_o = val_q;
  assign max_o = max_q;

endmodule

`default_nettype wire

// File: src/pilot_window_peak_state_classifier.sv
// ----------------------------------------------------------------------------
// Pilot window peak state classifier
// Converts control-pilot ADC codes to millivolts, keeps a sliding window of
// WINDOW_LEN values, and classifies the window peak into pilot states A..F.
//
// Usage:
//   Input words arrive on s_axis (tdata[11:0] = sample_code). Each accepted
//   word yields exactly one result word on m_axis (peak_mv, pilot_state).
//   Coefficients are written on the cfg channel (index 0 slope_q16, index 1
//   intercept_q16), which is always ready; write only while the block idles.
//   One word is in flight at a time: after acceptance the product register
//   loads, the next cycle pushes the value into the cell row, then the
//   running maximum ripples down the row to the last cell. A new word is
//   taken only once the result is loaded; the result sits in an output
//   register, so the next word is accepted while the receiver stalls; only
//   the following result waits for it.
//   Reset clears the window to 0 mV, the state to A and loads the default
//   coefficients.
// ----------------------------------------------------------------------------
`default_nettype none

module pilot_window_peak_state_classifier
  import pwpsc_pkg::*;
#(
  parameter int unsigned WINDOW_LEN = 50
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input words: [11:0] sample_code, upper bits zero.
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [15:0]         s_axis_tdata,
  // Result words: [14:0] peak_mv, [17:15] pilot_state, upper bits zero.
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,
  // Configuration writes.
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CntW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam logic [CntW-1:0] CntLast = CntW'(WINDOW_LEN - 1);

  fsm_e                  state_q;
  fsm_e                  state_d;
  logic [CntW-1:0]       cnt_q;
  logic [CntW-1:0]       cnt_d;
  logic [SlopeW-1:0]     slope_q;
  logic [InterceptW-1:0] intercept_q;
  pilot_e                pilot_q;
  pilot_e                pilot_d;
  mv_t                   peak_q;
  logic                  out_valid_q;
  logic                  in_accept;
  logic                  shift_en;
  logic                  out_load;
  mv_t                   conv_mv;
  mv_t                   val_w [WINDOW_LEN+1];
  mv_t                   max_w [WINDOW_LEN+1];

  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slope_q     <= SlopeW'(406290);
      intercept_q <= InterceptW'(867169731);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SLOPE:     slope_q     <= cfg_data_i[SlopeW-1:0];
        CFG_INTERCEPT: intercept_q <= cfg_data_i[InterceptW-1:0];
        default: ;
      endcase
    end
  end

  // Converter.
  pwpsc_conv u_conv (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (in_accept),
    .code_i      (s_axis_tdata[CodeW-1:0]),
    .slope_i     (slope_q),
    .intercept_i (intercept_q),
    .mv_o        (conv_mv)
  );

  // Row of window cells.
  assign val_w[0] = conv_mv;
  assign max_w[0] = MV_MIN;

  for (genvar i = 0; i < WINDOW_LEN; i++) begin : g_cell
    pwpsc_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (shift_en),
      .val_i   (val_w[i]),
      .max_i   (max_w[i]),
      .val_o   (val_w[i+1]),
      .max_o   (max_w[i+1])
    );
  end

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_accept) state_d = ST_SHIFT;
      ST_SHIFT: state_d = ST_SCAN;
      ST_SCAN:  if (cnt_q == CntLast) state_d = ST_DONE;
      ST_DONE:  if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Output decode.
  always_comb begin
    s_axis_tready = 1'b0;
    shift_en      = 1'b0;
    out_load      = 1'b0;
    cnt_d         = cnt_q;
    unique case (state_q)
      ST_IDLE:  s_axis_tready = 1'b1;
      ST_SHIFT: begin
        shift_en = 1'b1;
        cnt_d    = '0;
      end
      ST_SCAN:  cnt_d = cnt_q + 1'b1;
      ST_DONE:  out_load = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Classification and output register.
  assign pilot_d = classify(max_w[WINDOW_LEN], pilot_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pilot_q     <= PILOT_A;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        pilot_q     <= pilot_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      peak_q <= max_w[WINDOW_LEN];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, pilot_q, peak_q};

endmodule

`default_nettype wire

// File: bench/tb_pilot_window_peak_state_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pilot window peak state classifier testbench
// Streams pilot ADC codes into the block and predicts every result word.
// A scoreboard keeps its own copy of the millivolt window, the coefficient
// registers and the pilot state. Phases change the coefficients between
// runs and vary the idle and stall pressure on both stream sides.
// ----------------------------------------------------------------------------
module tb_pilot_window_peak_state_classifier;
  import pwpsc_pkg::*;

  localparam int unsigned WindowLen    = 50;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned LongHold     = 400;
  localparam int unsigned PhaseItems   = 255;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned ReportMax    = 10;

  // Window predictor plus the queue of expected result words.
  class pilot_peak_scoreboard;
    typedef struct {
      mv_t    peak;
      pilot_e state;
    } pilot_result_t;

    logic [SlopeW-1:0]     slope;
    logic [InterceptW-1:0] offset;
    int                    trail_mv [WindowLen];
    int unsigned           next_slot;
    pilot_e                held_state;
    pilot_result_t         expected_peaks [$];
    int unsigned           mismatches;

    function void power_on();
      slope  = 20'd406290;
      offset = 31'd867169731;
      foreach (trail_mv[i]) trail_mv[i] = 0;
      next_slot  = 0;
      held_state = PILOT_A;
      expected_peaks.delete();
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CFG_SLOPE: begin
          slope = data[SlopeW-1:0];
        end
        CFG_INTERCEPT: begin
          offset = data[InterceptW-1:0];
        end
        default: begin
        end
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_peaks.size();
    endfunction

    // Strict bands; edges and gaps leave the state as it was.
    function pilot_e classify_peak(int p, pilot_e prev);
      if (p > 10000) return PILOT_A;
      if (p < 10000 && p > 8000) return PILOT_B;
      if (p < 7000 && p > 5000) return PILOT_C;
      if (p < 4000 && p > 2000) return PILOT_D;
      if (p < 1000 && p > -1000) return PILOT_E;
      if (p < -11000 && p > -13000) return PILOT_F;
      return prev;
    endfunction

    // Smallest code whose voltage reaches the given level, for steering runs.
    function int code_near(int mv);
      longint num;
      if (slope == 0) return $urandom_range(4095);
      num = longint'(mv) * 65536 + longint'(offset);
      if (num <= 0) return 0;
      num = (num + longint'(slope) - 1) / longint'(slope);
      if (num > 4095) return 4095;
      return int'(num);
    endfunction

    function void note_sample(logic [CodeW-1:0] code);
      longint        acc;
      int            top;
      pilot_result_t res;
      // Floor of the Q16 difference, then saturate to the 15-bit range.
      acc = longint'(code) * longint'(slope) - longint'(offset);
      acc = acc >>> 16;
      if (acc < longint'(MV_MIN)) acc = longint'(MV_MIN);
      if (acc > longint'(MV_MAX)) acc = longint'(MV_MAX);
      trail_mv[next_slot] = int'(acc);
      next_slot = (next_slot + 1) % WindowLen;
      top = trail_mv[0];
      foreach (trail_mv[i]) begin
        if (trail_mv[i] > top) top = trail_mv[i];
      end
      held_state = classify_peak(top, held_state);
      res.peak  = mv_t'(top);
      res.state = held_state;
      expected_peaks.push_back(res);
    endfunction

    function void complain(string msg);
      mismatches++;
      if (mismatches <= ReportMax) $display("%0t: %s", $realtime, msg);
    endfunction

    function void check_result(logic [23:0] word);
      pilot_result_t     want;
      mv_t               got_peak;
      logic [StateW-1:0] got_state;
      got_peak  = word[MvW-1:0];
      got_state = word[MvW +: StateW];
      if (expected_peaks.size() == 0) begin
        complain($sformatf("result word %h (peak %0d state %0d) with no sample waiting",
                           word, got_peak, got_state));
        return;
      end
      want = expected_peaks.pop_front();
      if (got_peak !== want.peak) begin
        complain($sformatf("peak_mv expected %0d got %0d", want.peak, got_peak));
      end
      if (got_state !== want.state) begin
        complain($sformatf("pilot_state expected %0d (%s) got %0d",
                           want.state, want.state.name(), got_state));
      end
      if (word[23:MvW+StateW] !== '0) begin
        complain($sformatf("pad bits expected 0 got %h", word[23:MvW+StateW]));
      end
    endfunction
  endclass

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [15:0]         s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  pilot_peak_scoreboard sb;
  int unsigned src_idle_pct   = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned sink_hold_left = 0;
  int unsigned quiet_cycles   = 0;

  // Levels around every band edge, inside each band and in the gaps.
  int band_marks [26] = '{16383, 12000, 10001, 10000, 9999, 9000, 8001, 8000, 7999,
                          7500, 7000, 6000, 5000, 4500, 4000, 3000, 2000, 1000, 0,
                          -1000, -5000, -11000, -12000, -13000, -14000, -16384};
  // Rising levels for the directed climb, exact at 8 mV per code.
  int climb_marks [15] = '{0, 1000, 1008, 2000, 3000, 4000, 4504, 5000, 6000,
                           7000, 7504, 8000, 9000, 10000, 10008};

  pilot_window_peak_state_classifier dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off counted here.
  always @(posedge clk_i) begin
    if (sink_hold_left > 0) begin
      sink_hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Handshake monitor and watchdog on cycles without any accepted word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if (s_axis_tvalid && s_axis_tready) sb.note_sample(s_axis_tdata[CodeW-1:0]);
      if (cfg_valid_i && cfg_ready_o) sb.write_reg(cfg_index_i, cfg_data_i);
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Offer one code; valid stays high after the handshake for back-to-back words.
  task automatic send_sample(input logic [CodeW-1:0] code);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(16 - CodeW){1'b0}}, code};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // Register write; bits above the register width carry random junk.
  task automatic program_reg(input logic [CfgIdxW-1:0] idx,
                             input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] keep;
    keep = '1;
    if (idx == CFG_SLOPE) keep = (32'd1 << SlopeW) - 1;
    else if (idx == CFG_INTERCEPT) keep = (32'd1 << InterceptW) - 1;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= (value & keep) | ($urandom & ~keep);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Stop offering and wait until every predicted word has come back.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // One coefficient setting, then runs of similar codes so the window settles.
  task automatic run_phase(input logic [CfgDataW-1:0] slope_val,
                           input logic [CfgDataW-1:0] offset_val,
                           input int unsigned mode, input bit hold_sink);
    int unsigned sent;
    int unsigned run_len;
    int          lvl;
    int          code;
    drain_results();
    program_reg(CFG_SLOPE, slope_val);
    program_reg(CFG_INTERCEPT, offset_val);
    case (mode)
      1: begin
        src_idle_pct   = 62;
        sink_stall_pct = 0;
      end
      2: begin
        src_idle_pct   = 0;
        sink_stall_pct = 62;
      end
      3: begin
        src_idle_pct   = 30;
        sink_stall_pct = 30;
      end
      default: begin
        src_idle_pct   = 0;
        sink_stall_pct = 0;
      end
    endcase
    if (hold_sink) sink_hold_left = LongHold;
    sent = 0;
    while (sent < PhaseItems) begin
      if ($urandom_range(3) == 0) lvl = $urandom_range(4095);
      else lvl = sb.code_near(band_marks[$urandom_range($size(band_marks) - 1)]);
      run_len = ($urandom_range(3) == 0) ? $urandom_range(1, 20) : $urandom_range(50, 75);
      repeat (run_len) begin
        if ($urandom_range(7) == 0) begin
          code = $urandom_range(4095);
        end else if ($urandom_range(1) == 0) begin
          code = lvl;
        end else begin
          code = lvl + int'($urandom_range(6)) - 3;
        end
        if (code < 0) code = 0;
        if (code > 4095) code = 4095;
        send_sample(code[CodeW-1:0]);
        sent++;
      end
    end
  endtask

  initial begin
    sb = new;
    sb.power_on();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed climb through every band edge from 1000 mV to 10000 mV at 8 mV per code, 13008 mV offset.
    program_reg(CFG_SLOPE, 32'd524288);
    program_reg(CFG_INTERCEPT, 32'd852492288);
    foreach (climb_marks[i]) send_sample(CodeW'(sb.code_near(climb_marks[i])));
    send_sample(12'hFFF);
    send_sample(12'h000);

    run_phase(32'd406290, 32'd867169731, 0, 1'b0);
    run_phase(32'd65536, 32'd0, 1, 1'b0);
    run_phase(32'd1048575, 32'd2147483647, 2, 1'b1);
    run_phase(32'd0, 32'd0, 3, 1'b0);
    run_phase(32'd0, 32'd2147483647, 0, 1'b0);

    // Writes to unused indexes must leave the coefficients alone.
    drain_results();
    program_reg(2'd2, $urandom);
    program_reg(2'd3, $urandom);
    run_phase($urandom_range(0, 1048575), $urandom & 32'h7FFF_FFFF, 2, 1'b0);
    run_phase(32'd524288, 32'd852492288, 3, 1'b1);

    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
